// ===== hw/rtl/gepn_pkg.sv =====
package gepn_pkg;

	// Field and register geometry
	localparam int CW   = 16;
	localparam int FB   = 14;
	localparam int NEXT = 4;
	localparam int NREG = 2 * NEXT;
	localparam int IDXW = $clog2(NREG);
	localparam int VBIT = 3 * CW;
	localparam int REGW = VBIT + 1;

	// Datapath widths
	localparam int BB   = CW - 1;          // block form magnitude lies in [2^(BB-1), 2^BB)
	localparam int NW   = BB + 1;          // block form component width
	localparam int CSW  = CW + 2;          // centroid sum
	localparam int RW   = CW + 1;          // inner minus outer
	localparam int XPW  = CSW + RW;        // R x C partial product
	localparam int CCW  = 2 * NW + 1;      // cn.cn and rn.cn
	localparam int EPW  = NW + CCW;        // ex partial product
	localparam int EXW  = EPW + 1;         // ex before block form
	localparam int EYW  = 2 * NW + 1;      // ey before block form
	localparam int BFW  = EXW;             // block form unit input width
	localparam int SHW  = $clog2(BFW);     // block form shift amount
	localparam int BFL  = 4;               // block form unit latency
	localparam int PMW  = CW + NW;         // projection partial product
	localparam int PW   = PMW + 2;         // projection
	localparam int SPW  = PW + 1;          // span and remainder
	localparam int QW   = FB + 3;          // quotient bits
	localparam int OW   = FB + 2;          // output coordinate
	localparam int DVL  = QW + 2;          // clamp and map unit latency

	typedef enum logic [1:0] {
		EXT_INNER,
		EXT_OUTER,
		EXT_UP,
		EXT_DOWN
	} ext_t;

	typedef enum logic [IDXW-1:0] {
		REG_LEFT_INNER,
		REG_LEFT_OUTER,
		REG_LEFT_UP,
		REG_LEFT_DOWN,
		REG_RIGHT_INNER,
		REG_RIGHT_OUTER,
		REG_RIGHT_UP,
		REG_RIGHT_DOWN
	} reg_idx_t;

	typedef logic signed [CW-1:0]  comp_t;
	typedef comp_t [2:0]           vec_t;
	typedef logic signed [NW-1:0]  bcomp_t;
	typedef bcomp_t [2:0]          bvec_t;
	typedef logic signed [BFW-1:0] wcomp_t;
	typedef wcomp_t [2:0]          wvec_t;

	typedef struct packed {
		logic                  eye_side;
		logic signed [CW-1:0]  gaze_x;
		logic signed [CW-1:0]  gaze_y;
		logic signed [CW-1:0]  gaze_z;
	} in_t;

	typedef struct packed {
		logic [NEXT-1:0]       missing_mask;
		logic                  coords_valid;
		logic signed [OW-1:0]  eye_x;
		logic signed [OW-1:0]  eye_y;
	} out_t;

	// Status that travels with an item to the output
	typedef struct packed {
		logic [NEXT-1:0] mask;
		logic            bad;
	} sb_t;

	// Operands that travel with an item until the projections
	typedef struct packed {
		vec_t [NEXT-1:0] ext;
		vec_t            g;
		bvec_t           cn;
		bvec_t           exn;
	} ctx_t;

endpackage

// ===== hw/rtl/gepn_blkfrm.sv =====
module gepn_blkfrm (
	input  logic             clk,
	input  logic             en,
	input  gepn_pkg::wvec_t  vin,
	output gepn_pkg::bvec_t  res
);

	localparam int BFW = gepn_pkg::BFW;
	localparam int SHW = gepn_pkg::SHW;
	localparam int NW  = gepn_pkg::NW;
	localparam logic [SHW-1:0] TGT = SHW'(gepn_pkg::BB - 1);

	logic [BFW-1:0] mag_s1 [3];
	logic [2:0]     neg_s1;
	logic [BFW-1:0] mag_s2 [3];
	logic [2:0]     neg_s2;
	logic [BFW-1:0] max_s2;
	logic [BFW-1:0] mag_s3 [3];
	logic [2:0]     neg_s3;
	logic [SHW-1:0] sr_s3;
	logic [SHW-1:0] sl_s3;
	logic [BFW-1:0] m01;
	logic [SHW-1:0] pos;

	// Split each component into sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vin[i][BFW-1];
				mag_s1[i] <= vin[i][BFW-1] ? BFW'(-vin[i]) : BFW'(vin[i]);
			end
		end
	end

	// Largest magnitude
	assign m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			max_s2 <= (m01 > mag_s1[2]) ? m01 : mag_s1[2];
		end
	end

	// Locate the leading one and derive the common shift
	always_comb begin
		pos = '0;
		for (int b = 0; b < BFW; b++) begin
			if (max_s2[b]) pos = SHW'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
			sr_s3  <= (pos > TGT) ? pos - TGT : '0;
			sl_s3  <= (pos < TGT) ? TGT - pos : '0;
		end
	end

	// Apply the shift; a right shift truncates the magnitude
	always_ff @(posedge clk) begin
		logic [BFW-1:0] a;
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a = (mag_s3[i] >> sr_s3) << sl_s3;
				res[i] <= neg_s3[i] ? -$signed(a[NW-1:0]) : $signed(a[NW-1:0]);
			end
		end
	end

endmodule

// ===== hw/rtl/gepn_div.sv =====
module gepn_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [gepn_pkg::PW-1:0]   v,
	input  logic signed [gepn_pkg::PW-1:0]   lo,
	input  logic signed [gepn_pkg::PW-1:0]   hi,
	output logic signed [gepn_pkg::OW-1:0]   res
);

	localparam int SPW = gepn_pkg::SPW;
	localparam int QW  = gepn_pkg::QW;
	localparam int OW  = gepn_pkg::OW;
	localparam logic [OW-1:0] Q_ONE = OW'(1) << gepn_pkg::FB;

	logic signed [SPW-1:0] dlo_s1;
	logic signed [SPW-1:0] span_s1;
	logic                  lt_s1;
	logic                  gt_s1;
	logic                  ok_s1;

	// Index is the quotient step
	logic [SPW-1:0] rem_q  [QW];
	logic [SPW-1:0] span_q [QW];
	logic [QW-1:0]  quo_q  [QW];
	logic           ok_q   [QW];

	logic [QW:0]    qn;

	// Offsets, span and clamp decisions, all side by side
	always_ff @(posedge clk) begin
		if (en) begin
			dlo_s1  <= SPW'(v) - SPW'(lo);
			span_s1 <= SPW'(hi) - SPW'(lo);
			lt_s1   <= v < lo;
			gt_s1   <= v > hi;
			ok_s1   <= hi > lo;
		end
	end

	// One quotient bit per stage, restoring
	for (genvar k = 0; k < QW; k++) begin : g_step
		if (k == 0) begin : g_first
			logic [SPW-1:0] r0;
			always_comb begin
				if (lt_s1) begin
					r0 = '0;
				end else if (gt_s1) begin
					r0 = span_s1;
				end else begin
					r0 = dlo_s1;
				end
			end
			always_ff @(posedge clk) begin
				if (en) begin
					span_q[k] <= span_s1;
					ok_q[k]   <= ok_s1;
					if (r0 >= SPW'(span_s1)) begin
						rem_q[k] <= r0 - SPW'(span_s1);
						quo_q[k] <= QW'(1);
					end else begin
						rem_q[k] <= r0;
						quo_q[k] <= '0;
					end
				end
			end
		end else begin : g_next
			logic [SPW:0] rs;
			logic [SPW:0] dif;
			logic         ge;
			assign rs  = {rem_q[k-1], 1'b0};
			assign ge  = rs >= {1'b0, span_q[k-1]};
			assign dif = rs - {1'b0, span_q[k-1]};
			always_ff @(posedge clk) begin
				if (en) begin
					span_q[k] <= span_q[k-1];
					ok_q[k]   <= ok_q[k-1];
					quo_q[k]  <= {quo_q[k-1][QW-2:0], ge};
					rem_q[k]  <= ge ? dif[SPW-1:0] : rs[SPW-1:0];
				end
			end
		end
	end

	// Round half up and recentre onto [-1, +1]
	assign qn = {1'b0, quo_q[QW-1]} + (QW+1)'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			res <= ok_q[QW-1] ? $signed(OW'(qn[QW:1]) - Q_ONE) : '0;
		end
	end

endmodule

// ===== hw/rtl/gaze_extreme_projection_normalizer.sv =====
// Gaze normaliser: maps a 3-D gaze vector onto calibrated eye coordinates in [-1, +1]
// (Q1.14) for the selected eye. It is a fully pipelined datapath that takes one item
// per clock while the output is not held. Most of its stages lie in the block-form shift
// units (four stages each, three of them in series) and in the 17-step restoring
// division that maps each projection onto the calibrated span. When the output is
// held, the whole pipeline freezes and in_ready falls in the same cycle.
// The eight calibration extremes are written through cfg_we/cfg_index/cfg_wdata
// (bit 48 is the valid bit) and should only be changed while no item is in flight.
module gaze_extreme_projection_normalizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gepn_pkg::in_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gepn_pkg::out_t                out_data,
	input  logic                          cfg_we,
	input  logic [gepn_pkg::IDXW-1:0]     cfg_index,
	input  logic [gepn_pkg::REGW-1:0]     cfg_wdata
);

	localparam int CW    = gepn_pkg::CW;
	localparam int NEXT  = gepn_pkg::NEXT;
	localparam int NREG  = gepn_pkg::NREG;
	localparam int REGW  = gepn_pkg::REGW;
	localparam int BFW   = gepn_pkg::BFW;
	localparam int CSW   = gepn_pkg::CSW;
	localparam int RW    = gepn_pkg::RW;
	localparam int XPW   = gepn_pkg::XPW;
	localparam int NW    = gepn_pkg::NW;
	localparam int CCW   = gepn_pkg::CCW;
	localparam int EPW   = gepn_pkg::EPW;
	localparam int EXW   = gepn_pkg::EXW;
	localparam int EYW   = gepn_pkg::EYW;
	localparam int PMW   = gepn_pkg::PMW;
	localparam int PW    = gepn_pkg::PW;
	localparam int OW    = gepn_pkg::OW;

	// Stage numbers
	localparam int ST_CR   = 2;
	localparam int ST_BAS  = ST_CR + gepn_pkg::BFL;
	localparam int ST_CC   = ST_BAS + 1;
	localparam int ST_DOT  = ST_CC + 1;
	localparam int ST_EXP  = ST_DOT + 1;
	localparam int ST_EX   = ST_EXP + 1;
	localparam int ST_EXN  = ST_EX + gepn_pkg::BFL;
	localparam int ST_EYP  = ST_EXN + 1;
	localparam int ST_EY   = ST_EYP + 1;
	localparam int ST_EYN  = ST_EY + gepn_pkg::BFL;
	localparam int ST_PP   = ST_EYN + 1;
	localparam int ST_PS   = ST_PP + 1;
	localparam int ST_LAST = ST_PS + gepn_pkg::DVL;

	// Projection slots
	localparam int PJ_GX = 0;
	localparam int PJ_HX = 1;
	localparam int PJ_LX = 2;
	localparam int PJ_GY = 3;
	localparam int PJ_HY = 4;
	localparam int PJ_LY = 5;

	localparam logic signed [OW-1:0] Q_ONE = OW'(1) << gepn_pkg::FB;

	logic [REGW-1:0]       cfg_q [NREG];
	logic                  en;
	logic                  vld_q [1:ST_LAST];
	gepn_pkg::sb_t         sb_q  [1:ST_LAST];
	gepn_pkg::sb_t         sb_nxt [1:ST_LAST];
	gepn_pkg::ctx_t        ctx_q  [1:ST_EYN];
	gepn_pkg::ctx_t        ctx_nxt [1:ST_EYN];

	logic [REGW-1:0]       sel_c [NEXT];
	logic [NEXT-1:0]       mask_c;
	gepn_pkg::vec_t [NEXT-1:0] ext_c;
	gepn_pkg::vec_t        g_c;

	logic signed [CSW-1:0] c_s2 [3];
	logic signed [RW-1:0]  r_s2 [3];
	logic signed [XPW-1:0] xp_s3 [6];
	gepn_pkg::wvec_t       c_w;
	gepn_pkg::wvec_t       r_w;
	gepn_pkg::bvec_t       cn_m;
	gepn_pkg::bvec_t       rn_m;

	logic signed [2*NW-1:0] pcc_s7 [3];
	logic signed [2*NW-1:0] prc_s7 [3];
	gepn_pkg::bvec_t        rn_s7;
	logic signed [CCW-1:0]  cc_s8;
	logic signed [CCW-1:0]  rc_s8;
	gepn_pkg::bvec_t        rn_s8;
	logic signed [EPW-1:0]  ea_s9 [3];
	logic signed [EPW-1:0]  eb_s9 [3];
	gepn_pkg::wvec_t        ex_s10;
	gepn_pkg::bvec_t        exn_m;
	logic signed [2*NW-1:0] yp_s15 [6];
	gepn_pkg::wvec_t        ey_s16;
	gepn_pkg::bvec_t        eyn_m;

	gepn_pkg::vec_t         prj_a [6];
	gepn_pkg::bvec_t        prj_b [6];
	logic signed [PMW-1:0]  pr_s21 [6][3];
	logic signed [PW-1:0]   sm_s22 [6];
	logic signed [OW-1:0]   res_x;
	logic signed [OW-1:0]   res_y;
	logic                   ok_out;

	// Calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NREG; k++) cfg_q[k] <= '0;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_wdata;
		end
	end

	// Whole pipeline advances unless a finished item is held at the output
	assign en       = !vld_q[ST_LAST] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= ST_LAST; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[1] <= in_valid;
			for (int k = 2; k <= ST_LAST; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// Pick the extremes of the requested eye
	for (genvar k = 0; k < NEXT; k++) begin : g_sel
		assign sel_c[k] = in_data.eye_side ? cfg_q[gepn_pkg::REG_RIGHT_INNER + k]
		                                   : cfg_q[gepn_pkg::REG_LEFT_INNER + k];
	end

	always_comb begin
		for (int k = 0; k < NEXT; k++) begin
			mask_c[k] = ~sel_c[k][gepn_pkg::VBIT];
			for (int i = 0; i < 3; i++) ext_c[k][i] = sel_c[k][i*CW +: CW];
		end
		g_c[0] = in_data.gaze_x;
		g_c[1] = in_data.gaze_y;
		g_c[2] = in_data.gaze_z;
	end

	// Side data, with the degeneracy checks folded in where they resolve
	always_comb begin
		ctx_nxt[1].ext = ext_c;
		ctx_nxt[1].g   = g_c;
		ctx_nxt[1].cn  = '0;
		ctx_nxt[1].exn = '0;
		for (int k = 2; k <= ST_EYN; k++) ctx_nxt[k] = ctx_q[k-1];
		ctx_nxt[ST_CC].cn   = cn_m;
		ctx_nxt[ST_EYP].exn = exn_m;

		sb_nxt[1].mask = mask_c;
		sb_nxt[1].bad  = 1'b0;
		for (int k = 2; k <= ST_LAST; k++) sb_nxt[k] = sb_q[k-1];
		sb_nxt[ST_CR+1].bad = sb_q[ST_CR].bad
			| (c_s2[0] == '0 && c_s2[1] == '0 && c_s2[2] == '0);
		sb_nxt[ST_CR+2].bad = sb_q[ST_CR+1].bad
			| (xp_s3[0] == xp_s3[1] && xp_s3[2] == xp_s3[3] && xp_s3[4] == xp_s3[5]);
		sb_nxt[ST_EX+1].bad = sb_q[ST_EX].bad
			| (ex_s10[0] == '0 && ex_s10[1] == '0 && ex_s10[2] == '0);
		sb_nxt[ST_EY].bad = sb_q[ST_EYP].bad
			| (yp_s15[0] == yp_s15[1] && yp_s15[2] == yp_s15[3] && yp_s15[4] == yp_s15[5]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= ST_EYN; k++) ctx_q[k] <= ctx_nxt[k];
			for (int k = 1; k <= ST_LAST; k++) sb_q[k] <= sb_nxt[k];
		end
	end

	// Centroid sum and inner-outer axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= CSW'($signed(ctx_q[1].ext[gepn_pkg::EXT_INNER][i]))
				         + CSW'($signed(ctx_q[1].ext[gepn_pkg::EXT_OUTER][i]))
				         + CSW'($signed(ctx_q[1].ext[gepn_pkg::EXT_UP][i]))
				         + CSW'($signed(ctx_q[1].ext[gepn_pkg::EXT_DOWN][i]));
				r_s2[i] <= RW'($signed(ctx_q[1].ext[gepn_pkg::EXT_INNER][i]))
				         - RW'($signed(ctx_q[1].ext[gepn_pkg::EXT_OUTER][i]));
			end
		end
	end

	// R x C partial products; the cross product is zero when each pair matches
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s3[0] <= XPW'(r_s2[1]) * XPW'(c_s2[2]);
			xp_s3[1] <= XPW'(r_s2[2]) * XPW'(c_s2[1]);
			xp_s3[2] <= XPW'(r_s2[2]) * XPW'(c_s2[0]);
			xp_s3[3] <= XPW'(r_s2[0]) * XPW'(c_s2[2]);
			xp_s3[4] <= XPW'(r_s2[0]) * XPW'(c_s2[1]);
			xp_s3[5] <= XPW'(r_s2[1]) * XPW'(c_s2[0]);
		end
	end

	// Block forms of C and R
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_w[i] = BFW'(c_s2[i]);
			r_w[i] = BFW'(r_s2[i]);
		end
	end

	gepn_blkfrm u_bf_c (.clk(clk), .en(en), .vin(c_w), .res(cn_m));
	gepn_blkfrm u_bf_r (.clk(clk), .en(en), .vin(r_w), .res(rn_m));

	// ex = rn*(cn.cn) - (rn.cn)*cn
	always_ff @(posedge clk) begin
		if (en) begin
			rn_s7 <= rn_m;
			for (int i = 0; i < 3; i++) begin
				pcc_s7[i] <= (2*NW)'($signed(cn_m[i])) * (2*NW)'($signed(cn_m[i]));
				prc_s7[i] <= (2*NW)'($signed(rn_m[i])) * (2*NW)'($signed(cn_m[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s8 <= rn_s7;
			cc_s8 <= CCW'(pcc_s7[0]) + CCW'(pcc_s7[1]) + CCW'(pcc_s7[2]);
			rc_s8 <= CCW'(prc_s7[0]) + CCW'(prc_s7[1]) + CCW'(prc_s7[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ea_s9[i] <= EPW'($signed(rn_s8[i])) * EPW'(cc_s8);
				eb_s9[i] <= EPW'(rc_s8) * EPW'($signed(ctx_q[ST_DOT].cn[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) ex_s10[i] <= BFW'(EXW'(ea_s9[i]) - EXW'(eb_s9[i]));
		end
	end

	gepn_blkfrm u_bf_ex (.clk(clk), .en(en), .vin(ex_s10), .res(exn_m));

	// ey = cn x ex
	always_ff @(posedge clk) begin
		logic signed [NW-1:0] cn [3];
		logic signed [NW-1:0] ex [3];
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cn[i] = $signed(ctx_q[ST_EXN].cn[i]);
				ex[i] = $signed(exn_m[i]);
			end
			yp_s15[0] <= (2*NW)'(cn[1]) * (2*NW)'(ex[2]);
			yp_s15[1] <= (2*NW)'(cn[2]) * (2*NW)'(ex[1]);
			yp_s15[2] <= (2*NW)'(cn[2]) * (2*NW)'(ex[0]);
			yp_s15[3] <= (2*NW)'(cn[0]) * (2*NW)'(ex[2]);
			yp_s15[4] <= (2*NW)'(cn[0]) * (2*NW)'(ex[1]);
			yp_s15[5] <= (2*NW)'(cn[1]) * (2*NW)'(ex[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ey_s16[i] <= BFW'(EYW'(yp_s15[2*i]) - EYW'(yp_s15[2*i+1]));
			end
		end
	end

	gepn_blkfrm u_bf_ey (.clk(clk), .en(en), .vin(ey_s16), .res(eyn_m));

	// Project the gaze and the extremes onto ex and ey
	always_comb begin
		prj_a[PJ_GX] = ctx_q[ST_EYN].g;
		prj_a[PJ_HX] = ctx_q[ST_EYN].ext[gepn_pkg::EXT_INNER];
		prj_a[PJ_LX] = ctx_q[ST_EYN].ext[gepn_pkg::EXT_OUTER];
		prj_a[PJ_GY] = ctx_q[ST_EYN].g;
		prj_a[PJ_HY] = ctx_q[ST_EYN].ext[gepn_pkg::EXT_UP];
		prj_a[PJ_LY] = ctx_q[ST_EYN].ext[gepn_pkg::EXT_DOWN];
		prj_b[PJ_GX] = ctx_q[ST_EYN].exn;
		prj_b[PJ_HX] = ctx_q[ST_EYN].exn;
		prj_b[PJ_LX] = ctx_q[ST_EYN].exn;
		prj_b[PJ_GY] = eyn_m;
		prj_b[PJ_HY] = eyn_m;
		prj_b[PJ_LY] = eyn_m;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s21[j][i] <= PMW'($signed(prj_a[j][i])) * PMW'($signed(prj_b[j][i]));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				sm_s22[j] <= PW'(pr_s21[j][0]) + PW'(pr_s21[j][1]) + PW'(pr_s21[j][2]);
			end
		end
	end

	// Clamp and map each axis onto [-1, +1]
	gepn_div u_div_x (
		.clk(clk), .en(en),
		.v(sm_s22[PJ_GX]), .lo(sm_s22[PJ_LX]), .hi(sm_s22[PJ_HX]),
		.res(res_x)
	);

	gepn_div u_div_y (
		.clk(clk), .en(en),
		.v(sm_s22[PJ_GY]), .lo(sm_s22[PJ_LY]), .hi(sm_s22[PJ_HY]),
		.res(res_y)
	);

	// Result item
	assign ok_out                = (sb_q[ST_LAST].mask == '0) && !sb_q[ST_LAST].bad;
	assign out_valid             = vld_q[ST_LAST];
	assign out_data.missing_mask = sb_q[ST_LAST].mask;
	assign out_data.coords_valid = ok_out;
	assign out_data.eye_x        = ok_out ? res_x : '0;
	assign out_data.eye_y        = ok_out ? res_y : '0;

	// A live centroid and axis always give a nonzero block form
	a_basis_live: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_BAS] && sb_q[ST_BAS].mask == '0 && !sb_q[ST_BAS].bad
		|-> cn_m != '0 && rn_m != '0)
		else $error("block form of centroid or axis is zero on a live item");

	a_ey_live: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_EYN] && sb_q[ST_EYN].mask == '0 && !sb_q[ST_EYN].bad
		|-> eyn_m != '0)
		else $error("block form of ey is zero on a live item");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.coords_valid
		|-> $signed(out_data.eye_x) >= -Q_ONE && $signed(out_data.eye_x) <= Q_ONE
		 && $signed(out_data.eye_y) >= -Q_ONE && $signed(out_data.eye_y) <= Q_ONE)
		else $error("mapped coordinate outside [-1, +1]");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(sb_q[ST_LAST]) && $stable(res_x) && $stable(res_y))
		else $error("held result changed while the pipeline was frozen");

endmodule

// ===== bench/gaze_extreme_projection_normalizer_tb.sv =====
module gaze_extreme_projection_normalizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW   = gepn_pkg::CW;
	localparam int FB   = gepn_pkg::FB;
	localparam int BB   = gepn_pkg::BB;
	localparam int OW   = gepn_pkg::OW;
	localparam int NEXT = gepn_pkg::NEXT;
	localparam int NREG = gepn_pkg::NREG;
	localparam int IDXW = gepn_pkg::IDXW;
	localparam int VBIT = gepn_pkg::VBIT;
	localparam int REGW = gepn_pkg::REGW;

	typedef logic [REGW-1:0] cal_t;

	typedef struct {
		bit                 is_cfg;
		gepn_pkg::reg_idx_t idx;
		cal_t               wdata;
		gepn_pkg::in_t      item;
		bit                 chk;
		gepn_pkg::out_t     want;
	} step_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	gepn_pkg::in_t     in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	gepn_pkg::out_t    out_data;
	logic              cfg_we = 1'b0;
	logic [IDXW-1:0]   cfg_index = '0;
	cal_t              cfg_wdata = '0;

	// Shadow of the calibration registers and the queue of predicted coordinates
	cal_t            cal_shadow [NREG];
	gepn_pkg::out_t  coords_due [$];
	step_t           script [$];
	bit              failed = 1'b0;
	int              burst_left = 0;
	int              items_sent = 0;
	int              ready_mode = 0;
	int              ready_cnt = 0;

	gaze_extreme_projection_normalizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #6 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic cal_t pack_ext(bit ok, int x, int y, int z);
		gepn_pkg::comp_t cx, cy, cz;
		cx = gepn_pkg::comp_t'(x);
		cy = gepn_pkg::comp_t'(y);
		cz = gepn_pkg::comp_t'(z);
		return {ok, cz, cy, cx};
	endfunction

	function automatic longint dot3(longint a [3], longint b [3]);
		return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3],
			output longint r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic bit all_zero(longint v [3]);
		return v[0] == 0 && v[1] == 0 && v[2] == 0;
	endfunction

	// Shift by one common amount so that the largest magnitude lies in [2^14, 2^15)
	function automatic void to_block(inout longint v [3]);
		longint m, a;
		int sr, sl;
		m = 0;
		sr = 0;
		sl = 0;
		for (int i = 0; i < 3; i++) begin
			a = v[i] < 0 ? -v[i] : v[i];
			if (a > m) m = a;
		end
		if (m == 0) return;
		while (m >= (64'sd1 << BB)) begin
			m = m >> 1;
			sr++;
		end
		while (m < (64'sd1 << (BB - 1))) begin
			m = m << 1;
			sl++;
		end
		for (int i = 0; i < 3; i++) begin
			a = v[i] < 0 ? -v[i] : v[i];
			a = (a >> sr) << sl;
			v[i] = v[i] < 0 ? -a : a;
		end
	endfunction

	// Clamp onto [lo, hi] and rescale to [-1, +1], rounded half up
	function automatic longint span_map(longint v, longint lo, longint hi);
		longint span, rem, q;
		if (hi - lo <= 0) return 0;
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		span = hi - lo;
		rem = v - lo;
		q = 0;
		if (rem >= span) begin
			q = 1;
			rem -= span;
		end
		for (int i = 0; i < FB + 2; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= span) begin
				rem -= span;
				q = q | 1;
			end
		end
		return ((q + 1) >> 1) - (64'sd1 << FB);
	endfunction

	function automatic gepn_pkg::out_t predict_coords(gepn_pkg::in_t it);
		gepn_pkg::out_t  o;
		cal_t            rg [NEXT];
		longint          e [NEXT][3];
		longint          g [3], c [3], r [3], cn [3], ex [3], ey [3], t [3];
		longint          cc, rc, px, py;
		gepn_pkg::comp_t cv;
		int              base;
		o = '0;
		base = it.eye_side ? int'(gepn_pkg::REG_RIGHT_INNER) : int'(gepn_pkg::REG_LEFT_INNER);
		for (int k = 0; k < NEXT; k++) begin
			rg[k] = cal_shadow[base + k];
			if (!rg[k][VBIT]) o.missing_mask[k] = 1'b1;
		end
		if (o.missing_mask != 0) return o;
		for (int k = 0; k < NEXT; k++)
			for (int i = 0; i < 3; i++) begin
				cv = rg[k][i*CW +: CW];
				e[k][i] = longint'(cv);
			end
		g[0] = longint'(it.gaze_x);
		g[1] = longint'(it.gaze_y);
		g[2] = longint'(it.gaze_z);
		for (int i = 0; i < 3; i++) begin
			c[i] = e[gepn_pkg::EXT_INNER][i] + e[gepn_pkg::EXT_OUTER][i]
				+ e[gepn_pkg::EXT_UP][i] + e[gepn_pkg::EXT_DOWN][i];
			r[i] = e[gepn_pkg::EXT_INNER][i] - e[gepn_pkg::EXT_OUTER][i];
		end
		if (all_zero(c)) return o;
		cross3(r, c, t);
		if (all_zero(t)) return o;
		cn = c;
		to_block(cn);
		to_block(r);
		cc = dot3(cn, cn);
		rc = dot3(r, cn);
		for (int i = 0; i < 3; i++) ex[i] = r[i] * cc - rc * cn[i];
		if (all_zero(ex)) return o;
		to_block(ex);
		cross3(cn, ex, ey);
		if (all_zero(ey)) return o;
		to_block(ey);
		px = span_map(dot3(g, ex), dot3(e[gepn_pkg::EXT_OUTER], ex),
			dot3(e[gepn_pkg::EXT_INNER], ex));
		py = span_map(dot3(g, ey), dot3(e[gepn_pkg::EXT_DOWN], ey),
			dot3(e[gepn_pkg::EXT_UP], ey));
		o.coords_valid = 1'b1;
		o.eye_x = px[OW-1:0];
		o.eye_y = py[OW-1:0];
		return o;
	endfunction

	// ---------------------------------------------------------------- drivers

	task automatic cal_write(gepn_pkg::reg_idx_t idx, cal_t d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		cal_shadow[idx] = d;
		@(posedge clk);
	endtask

	// Hold the item until taken, then idle between bursts
	task automatic send_gaze(gepn_pkg::in_t it, bit chk, gepn_pkg::out_t want);
		int gap;
		cfg_we <= 1'b0;
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		coords_due = {coords_due, (chk ? want : predict_coords(it))};
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 15);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (coords_due.size() != 0) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- random content

	task automatic random_eye(bit right);
		cal_t               ext [NEXT];
		int                 kind, zb, zs, sel;
		cal_t               tmp;
		gepn_pkg::reg_idx_t base;
		base = right ? gepn_pkg::REG_RIGHT_INNER : gepn_pkg::REG_LEFT_INNER;
		kind = $urandom_range(0, 9);
		zb = $urandom_range(8000, 16000);
		zs = ($urandom_range(0, 4) == 0) ? -1 : 1;
		ext[gepn_pkg::EXT_INNER] = pack_ext(1, $urandom_range(2000, 9000),
			int'($urandom_range(0, 2000)) - 1000, zs * (zb + int'($urandom_range(0, 1000))));
		ext[gepn_pkg::EXT_OUTER] = pack_ext(1, -int'($urandom_range(2000, 9000)),
			int'($urandom_range(0, 2000)) - 1000, zs * (zb + int'($urandom_range(0, 1000))));
		ext[gepn_pkg::EXT_UP] = pack_ext(1, int'($urandom_range(0, 2000)) - 1000,
			$urandom_range(2000, 8000), zs * (zb + int'($urandom_range(0, 1000))));
		ext[gepn_pkg::EXT_DOWN] = pack_ext(1, int'($urandom_range(0, 2000)) - 1000,
			-int'($urandom_range(2000, 8000)), zs * (zb + int'($urandom_range(0, 1000))));
		sel = $urandom_range(0, NEXT - 1);
		case (kind)
			7: begin
				// noise: any bits, valid mostly set
				for (int k = 0; k < NEXT; k++) begin
					ext[k] = {$urandom_range(0, 3) != 0, 16'($urandom), 16'($urandom),
						16'($urandom)};
				end
			end
			8: begin
				ext[sel][VBIT] = 1'b0;
			end
			9: begin
				// swapped pair or a collapsed inner-outer axis
				if (sel == 0) begin
					ext[gepn_pkg::EXT_OUTER] = ext[gepn_pkg::EXT_INNER];
				end else if (sel == 1) begin
					tmp = ext[gepn_pkg::EXT_UP];
					ext[gepn_pkg::EXT_UP] = ext[gepn_pkg::EXT_DOWN];
					ext[gepn_pkg::EXT_DOWN] = tmp;
				end else begin
					tmp = ext[gepn_pkg::EXT_INNER];
					ext[gepn_pkg::EXT_INNER] = ext[gepn_pkg::EXT_OUTER];
					ext[gepn_pkg::EXT_OUTER] = tmp;
				end
			end
			default: ;
		endcase
		for (int k = 0; k < NEXT; k++) cal_write(gepn_pkg::reg_idx_t'(base + k), ext[k]);
	endtask

	function automatic gepn_pkg::in_t random_gaze();
		gepn_pkg::in_t it;
		int            pick;
		it.eye_side = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 19);
		if (pick < 7) begin
			it.gaze_x = CW'($urandom);
			it.gaze_y = CW'($urandom);
			it.gaze_z = CW'($urandom);
		end else if (pick < 9) begin
			// land exactly on a calibration extreme
			it.gaze_x = cal_shadow[it.eye_side * NEXT + pick - 7][0 +: CW];
			it.gaze_y = cal_shadow[it.eye_side * NEXT + pick - 7][CW +: CW];
			it.gaze_z = cal_shadow[it.eye_side * NEXT + pick - 7][2*CW +: CW];
		end else begin
			it.gaze_x = CW'(int'($urandom_range(0, 24000)) - 12000);
			it.gaze_y = CW'(int'($urandom_range(0, 20000)) - 10000);
			it.gaze_z = CW'(int'($urandom_range(0, 6000)) + 10000);
			if ($urandom_range(0, 4) == 0) it.gaze_z = -it.gaze_z;
		end
		return it;
	endfunction

	// ---------------------------------------------------------------- directed script

	function automatic step_t blank_step();
		step_t s;
		s.is_cfg = 1'b0;
		s.idx = gepn_pkg::REG_LEFT_INNER;
		s.wdata = '0;
		s.item = '0;
		s.chk = 1'b0;
		s.want = '0;
		return s;
	endfunction

	function automatic step_t cal_step(gepn_pkg::reg_idx_t idx, cal_t d);
		step_t s;
		s = blank_step();
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.wdata = d;
		return s;
	endfunction

	function automatic step_t gaze_step(bit eye, int x, int y, int z, bit chk,
			int mask, bit ok, int ex, int ey);
		step_t s;
		s = blank_step();
		s.item.eye_side = eye;
		s.item.gaze_x = CW'(x);
		s.item.gaze_y = CW'(y);
		s.item.gaze_z = CW'(z);
		s.chk = chk;
		s.want.missing_mask = NEXT'(mask);
		s.want.coords_valid = ok;
		s.want.eye_x = OW'(ex);
		s.want.eye_y = OW'(ey);
		return s;
	endfunction

	function automatic void add_row(step_t s);
		script = {script, s};
	endfunction

	task automatic build_script;
		// nothing calibrated after reset
		add_row(gaze_step(0, 0, 0, 16384, 1, 15, 0, 0, 0));
		add_row(gaze_step(1, 32767, -32768, 0, 1, 15, 0, 0, 0));
		// nominal left eye looking down +z
		add_row(cal_step(gepn_pkg::REG_LEFT_INNER, pack_ext(1, 6000, 0, 15000)));
		add_row(cal_step(gepn_pkg::REG_LEFT_OUTER, pack_ext(1, -6000, 0, 15000)));
		add_row(cal_step(gepn_pkg::REG_LEFT_UP, pack_ext(1, 0, 5000, 15000)));
		add_row(cal_step(gepn_pkg::REG_LEFT_DOWN, pack_ext(1, 0, -5000, 15000)));
		add_row(gaze_step(0, 6000, 0, 15000, 1, 0, 1, 16384, 0));
		add_row(gaze_step(0, -6000, 0, 15000, 1, 0, 1, -16384, 0));
		add_row(gaze_step(0, 0, 5000, 15000, 1, 0, 1, 0, 16384));
		add_row(gaze_step(0, 0, -5000, 15000, 1, 0, 1, 0, -16384));
		add_row(gaze_step(0, 0, 0, 16384, 1, 0, 1, 0, 0));
		add_row(gaze_step(0, 32767, -32768, 0, 1, 0, 1, 16384, -16384));
		add_row(gaze_step(0, -32768, 32767, -32768, 1, 0, 1, -16384, 16384));
		add_row(gaze_step(0, 1234, -777, 14000, 0, 0, 0, 0, 0));
		add_row(gaze_step(1, 0, 0, 16384, 1, 15, 0, 0, 0));
		// right eye with the up extreme missing
		add_row(cal_step(gepn_pkg::REG_RIGHT_INNER, pack_ext(1, 100, 0, 0)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_OUTER, pack_ext(1, -100, 0, 0)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_UP, pack_ext(0, 0, 100, 0)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_DOWN, pack_ext(1, 0, -100, 0)));
		add_row(gaze_step(1, 0, 0, 16384, 1, 4, 0, 0, 0));
		// zero centroid
		add_row(cal_step(gepn_pkg::REG_RIGHT_UP, pack_ext(1, 0, 100, 0)));
		add_row(gaze_step(1, 500, 0, 16384, 1, 0, 0, 0, 0));
		// inner equal to outer: axis parallel to the centroid
		add_row(cal_step(gepn_pkg::REG_RIGHT_INNER, pack_ext(1, 5000, 0, 15000)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_OUTER, pack_ext(1, 5000, 0, 15000)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_UP, pack_ext(1, 0, 5000, 15000)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_DOWN, pack_ext(1, 0, -5000, 15000)));
		add_row(gaze_step(1, 5000, 0, 15000, 1, 0, 0, 0, 0));
		// up and down swapped: inverted vertical span
		add_row(cal_step(gepn_pkg::REG_LEFT_UP, pack_ext(1, 0, -5000, 15000)));
		add_row(cal_step(gepn_pkg::REG_LEFT_DOWN, pack_ext(1, 0, 5000, 15000)));
		add_row(gaze_step(0, 6000, 0, 15000, 1, 0, 1, 16384, 0));
		add_row(gaze_step(0, -3000, 2000, 15000, 0, 0, 0, 0, 0));
		// extreme component values
		add_row(cal_step(gepn_pkg::REG_RIGHT_INNER, pack_ext(1, 32767, -32768, 32767)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_OUTER, pack_ext(1, -32768, 32767, 32767)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_UP, pack_ext(1, -32768, 32767, -32768)));
		add_row(cal_step(gepn_pkg::REG_RIGHT_DOWN, pack_ext(1, 32767, -32768, 32767)));
		add_row(gaze_step(1, 32767, 32767, 32767, 0, 0, 0, 0, 0));
		add_row(gaze_step(1, -32768, -32768, -32768, 0, 0, 0, 0, 0));
		add_row(gaze_step(1, 0, 0, 0, 0, 0, 0, 0, 0));
	endtask

	// ---------------------------------------------------------------- receiver

	// Stall on a pattern that switches between four ready modes, drawn at random
	always @(posedge clk) begin
		ready_cnt <= ready_cnt + 1;
		if (ready_cnt % 150 == 0) ready_mode <= $urandom_range(0, 3);
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= $urandom_range(0, 6) != 0;
			default: out_ready <= (ready_cnt % 16) < 4;
		endcase
	end

	// Compare each result with the oldest predicted coordinates
	always @(posedge clk) begin
		gepn_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (coords_due.size() == 0) begin
				$display("%t: unexpected result %p", $realtime, out_data);
				failed = 1'b1;
			end else begin
				want = coords_due.pop_front();
				if (out_data.missing_mask !== want.missing_mask) begin
					$display("%t: missing_mask expected %h got %h", $realtime,
						want.missing_mask, out_data.missing_mask);
					failed = 1'b1;
				end
				if (out_data.coords_valid !== want.coords_valid) begin
					$display("%t: coords_valid expected %b got %b", $realtime,
						want.coords_valid, out_data.coords_valid);
					failed = 1'b1;
				end
				if (out_data.eye_x !== want.eye_x) begin
					$display("%t: eye_x expected %0d got %0d", $realtime,
						want.eye_x, out_data.eye_x);
					failed = 1'b1;
				end
				if (out_data.eye_y !== want.eye_y) begin
					$display("%t: eye_y expected %0d got %0d", $realtime,
						want.eye_y, out_data.eye_y);
					failed = 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		for (int i = 0; i < NREG; i++) cal_shadow[i] = '0;
		build_script();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed script
		foreach (script[n]) begin
			if (script[n].is_cfg) begin
				drain();
				cal_write(script[n].idx, script[n].wdata);
			end else begin
				send_gaze(script[n].item, script[n].chk, script[n].want);
			end
		end

		// Random phases: fresh calibration, then a run of gaze items
		while (items_sent < 1650) begin
			drain();
			random_eye(1'b0);
			random_eye(1'b1);
			repeat ($urandom_range(60, 140)) send_gaze(random_gaze(), 1'b0, '0);
		end

		drain();
		cfg_we <= 1'b0;
		repeat (60) @(posedge clk);
		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
